/* design/isu_pkg.sv */
// isu_pkg: shared sizes, beat types, op and status codes for the interval union set unit
// holds the datapath command codes and status flags passed between controller and datapath
// depends on nothing; imported by every module of the block
package isu_pkg;

    // sizing
    localparam int MAX_INTERVALS = 64;
    localparam int VALUE_BITS    = 24;
    localparam int SLOTS         = 2 * MAX_INTERVALS;
    localparam int ADDR_W        = $clog2(SLOTS);
    localparam int PTR_W         = $clog2(SLOTS + 1);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

    // item opcodes
    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_BEGIN   = 2'd1,
        OP_TEST    = 2'd2,
        OP_ADVANCE = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ORDER = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // input beat
    typedef struct packed {
        t_op                   op;
        logic [VALUE_BITS-1:0] range_start;
        logic [VALUE_BITS-1:0] range_end;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic             inside_res;
        t_status          status;
        logic [CNT_W-1:0] interval_count;
    } t_out_beat;

    // one datapath operation per cycle
    typedef enum logic [4:0] {
        DP_NOP       = 5'd0,
        DP_LOAD      = 5'd1,
        DP_RD_P      = 5'd2,
        DP_A_NEXT    = 5'd3,
        DP_SET_I     = 5'd4,
        DP_B_NEXT    = 5'd5,
        DP_B_STOP    = 5'd6,
        DP_FIX       = 5'd7,
        DP_REJ_ORDER = 5'd8,
        DP_REJ_FULL  = 5'd9,
        DP_SH_RD     = 5'd10,
        DP_SH_WR     = 5'd11,
        DP_WR_LO     = 5'd12,
        DP_WR_HI     = 5'd13,
        DP_SCAN_CLR  = 5'd14,
        DP_SCAN_INC  = 5'd15,
        DP_RD_T0     = 5'd16,
        DP_RD_T1     = 5'd17,
        DP_INSIDE    = 5'd18,
        DP_K_INC     = 5'd19,
        DP_T2_EVAL   = 5'd20,
        DP_EMIT      = 5'd21
    } t_dp_op;

    // datapath flags seen by the controller
    typedef struct packed {
        t_op  op;
        logic bad_order;
        logic p_end;
        logic lt_s;
        logic le_e;
        logic full;
        logic sh_done;
        logic k_end;
        logic v_lt;
        logic v_le;
        logic out_free;
    } t_dp_sts;

endpackage

/* design/isu_dp.sv */
// isu_dp: datapath of the interval union set unit
// holds the boundary memory, add search and shift registers, scan state and output register
// depends on isu_pkg; driven one operation per cycle by isu_ctrl
module isu_dp import isu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_op    i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    // boundary memory and its registered read data
    logic [VALUE_BITS-1:0] mem [SLOTS];
    logic [VALUE_BITS-1:0] r_rdata;

    // latched item
    t_op                   r_op;
    logic [VALUE_BITS-1:0] r_s;
    logic [VALUE_BITS-1:0] r_e;

    // add search and merge
    logic [PTR_W-1:0]      r_p;
    logic [PTR_W-1:0]      r_i;
    logic [VALUE_BITS-1:0] r_prev;
    logic [VALUE_BITS-1:0] r_cand;
    logic [PTR_W-1:0]      r_i_eff;
    logic [VALUE_BITS-1:0] r_lo;
    logic [VALUE_BITS-1:0] r_hi;
    logic [PTR_W-1:0]      r_newcnt;

    // boundary move
    logic [PTR_W-1:0]      r_src;
    logic [PTR_W-1:0]      r_dst;
    logic [PTR_W-1:0]      r_cnt;
    logic                  r_dir;

    // persistent state
    logic [CNT_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_k;
    logic [VALUE_BITS-1:0] r_v;

    // result
    logic                  r_inside;
    t_status               r_status;
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic [PTR_W-1:0]      nb;
    logic [PTR_W-1:0]      i_eff_c;
    logic [PTR_W-1:0]      j_eff_c;
    logic [PTR_W-1:0]      span_c;
    logic [PTR_W-1:0]      newcnt_c;
    logic [VALUE_BITS-1:0] lo_c;
    logic [VALUE_BITS-1:0] hi_c;
    logic                  right_c;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr_en;
    logic                  out_free;

    // merge span from the two search positions
    assign nb       = PTR_W'({r_n, 1'b0});
    assign i_eff_c  = r_i[0] ? r_i - PTR_W'(1) : r_i;
    assign j_eff_c  = r_p[0] ? r_p + PTR_W'(1) : r_p;
    assign lo_c     = r_i[0] ? r_prev : r_s;
    assign hi_c     = r_p[0] ? r_cand : r_e;
    assign span_c   = j_eff_c - i_eff_c;
    assign newcnt_c = PTR_W'(r_n) + PTR_W'(1) - (span_c >> 1);
    assign right_c  = (j_eff_c == i_eff_c);
    assign out_free = !r_out_valid || !i_out_stall;

    // read address select
    always_comb begin
        unique case (i_cmd)
            DP_SH_RD: rd_addr = r_src[ADDR_W-1:0];
            DP_RD_T0: rd_addr = ADDR_W'({r_k, 1'b0});
            DP_RD_T1: rd_addr = ADDR_W'({r_k, 1'b1});
            default:  rd_addr = r_p[ADDR_W-1:0];
        endcase
    end

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_dst[ADDR_W-1:0];
        wr_data = r_rdata;
        unique case (i_cmd)
            DP_SH_WR: begin
                wr_en = 1'b1;
            end
            DP_WR_LO: begin
                wr_en   = 1'b1;
                wr_addr = r_i_eff[ADDR_W-1:0];
                wr_data = r_lo;
            end
            DP_WR_HI: begin
                wr_en   = 1'b1;
                wr_addr = r_i_eff[ADDR_W-1:0] + ADDR_W'(1);
                wr_data = r_hi;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // boundary memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_LOAD: begin
                r_op     <= i_in_data.op;
                r_s      <= i_in_data.range_start;
                r_e      <= i_in_data.range_end;
                r_p      <= '0;
                r_inside <= 1'b0;
                r_status <= ST_OK;
            end
            DP_A_NEXT: begin
                r_prev <= r_rdata;
                r_p    <= r_p + PTR_W'(1);
            end
            DP_SET_I: begin
                r_i <= r_p;
            end
            DP_B_NEXT: begin
                r_p <= r_p + PTR_W'(1);
            end
            DP_B_STOP: begin
                r_cand <= r_rdata;
            end
            DP_FIX: begin
                r_i_eff  <= i_eff_c;
                r_lo     <= lo_c;
                r_hi     <= hi_c;
                r_newcnt <= newcnt_c;
                r_cnt    <= nb - j_eff_c;
                r_dir    <= right_c;
                if (right_c) begin
                    r_src <= nb - PTR_W'(1);
                    r_dst <= nb + PTR_W'(1);
                end else begin
                    r_src <= j_eff_c;
                    r_dst <= i_eff_c + PTR_W'(2);
                end
            end
            DP_SH_WR: begin
                r_cnt <= r_cnt - PTR_W'(1);
                if (r_dir) begin
                    r_src <= r_src - PTR_W'(1);
                    r_dst <= r_dst - PTR_W'(1);
                end else begin
                    r_src <= r_src + PTR_W'(1);
                    r_dst <= r_dst + PTR_W'(1);
                end
            end
            DP_REJ_ORDER: begin
                r_status <= ST_BAD_ORDER;
            end
            DP_REJ_FULL: begin
                r_status <= ST_FULL;
            end
            DP_INSIDE: begin
                r_inside <= 1'b1;
            end
            DP_T2_EVAL: begin
                r_inside <= (r_v >= r_rdata);
            end
            DP_EMIT: begin
                r_out.inside_res     <= r_inside;
                r_out.status         <= r_status;
                r_out.interval_count <= r_n;
            end
            default: begin
            end
        endcase
    end

    // stored count, scan state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_k         <= '0;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd)
                DP_WR_HI:    r_n <= CNT_W'(r_newcnt);
                DP_SCAN_CLR: begin
                    r_k <= '0;
                    r_v <= '0;
                end
                DP_SCAN_INC: r_v <= r_v + VALUE_BITS'(1);
                DP_K_INC:    r_k <= r_k + CNT_W'(1);
                default: begin
                end
            endcase
            if (i_cmd == DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // flags for the controller
    always_comb begin
        o_sts.op        = r_op;
        o_sts.bad_order = (r_s >= r_e);
        o_sts.p_end     = (r_p >= nb);
        o_sts.lt_s      = (r_rdata < r_s);
        o_sts.le_e      = (r_rdata <= r_e);
        o_sts.full      = (r_newcnt > PTR_W'(MAX_INTERVALS));
        o_sts.sh_done   = (r_cnt == '0);
        o_sts.k_end     = (r_k >= r_n);
        o_sts.v_lt      = (r_v < r_rdata);
        o_sts.v_le      = (r_v <= r_rdata);
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // stored count stays within capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_INTERVALS))
        else $error("interval count above capacity");

    // a commit never follows a full verdict
    a_commit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == DP_WR_HI |-> r_newcnt <= PTR_W'(MAX_INTERVALS) && r_newcnt != '0)
        else $error("commit of an out of range count");

    // result only loaded into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == DP_EMIT |-> out_free)
        else $error("result overwrote a waiting beat");

    // move direction keeps unread boundaries intact
    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == DP_SH_WR |-> (r_dir ? (r_dst == r_src + PTR_W'(2)) : (r_dst <= r_src)))
        else $error("boundary move would clobber unread data");

    // search step never runs past the list
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_A_NEXT || i_cmd == DP_B_NEXT) |-> r_p < nb)
        else $error("search stepped past the boundary list");

endmodule

/* design/isu_ctrl.sv */
// isu_ctrl: controller state machine of the interval union set unit
// sequences add search, boundary move, scan test and result handoff
// depends on isu_pkg; commands isu_dp through one opcode per cycle
module isu_ctrl import isu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_op  o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_DISP   = 17'h00002,
        S_A_RD   = 17'h00004,
        S_A_CMP  = 17'h00008,
        S_B_RD   = 17'h00010,
        S_B_CMP  = 17'h00020,
        S_FIX    = 17'h00040,
        S_CHK    = 17'h00080,
        S_SH_RD  = 17'h00100,
        S_SH_WR  = 17'h00200,
        S_WR_HI  = 17'h00400,
        S_T0_RD  = 17'h00800,
        S_T0_CMP = 17'h01000,
        S_T1_CMP = 17'h02000,
        S_T2_RD  = 17'h04000,
        S_T2_CMP = 17'h08000,
        S_FIN    = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        o_cmd   = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    OP_ADD: begin
                        if (i_sts.bad_order) begin
                            o_cmd   = DP_REJ_ORDER;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end
                    OP_BEGIN: begin
                        o_cmd   = DP_SCAN_CLR;
                        n_state = S_FIN;
                    end
                    OP_TEST: begin
                        n_state = S_T0_RD;
                    end
                    default: begin
                        o_cmd   = DP_SCAN_INC;
                        n_state = S_FIN;
                    end
                endcase
            end
            // first boundary not below the start
            S_A_RD: begin
                if (i_sts.p_end) begin
                    o_cmd   = DP_SET_I;
                    n_state = S_B_RD;
                end else begin
                    o_cmd   = DP_RD_P;
                    n_state = S_A_CMP;
                end
            end
            S_A_CMP: begin
                if (i_sts.lt_s) begin
                    o_cmd   = DP_A_NEXT;
                    n_state = S_A_RD;
                end else begin
                    o_cmd   = DP_SET_I;
                    n_state = S_B_RD;
                end
            end
            // first boundary above the end
            S_B_RD: begin
                if (i_sts.p_end) begin
                    n_state = S_FIX;
                end else begin
                    o_cmd   = DP_RD_P;
                    n_state = S_B_CMP;
                end
            end
            S_B_CMP: begin
                if (i_sts.le_e) begin
                    o_cmd   = DP_B_NEXT;
                    n_state = S_B_RD;
                end else begin
                    o_cmd   = DP_B_STOP;
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd   = DP_FIX;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.full) begin
                    o_cmd   = DP_REJ_FULL;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            // move the tail, then write the merged pair
            S_SH_RD: begin
                if (i_sts.sh_done) begin
                    o_cmd   = DP_WR_LO;
                    n_state = S_WR_HI;
                end else begin
                    o_cmd   = DP_SH_RD;
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd   = DP_SH_WR;
                n_state = S_SH_RD;
            end
            S_WR_HI: begin
                o_cmd   = DP_WR_HI;
                n_state = S_FIN;
            end
            // test against the current interval
            S_T0_RD: begin
                if (i_sts.k_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_RD_T0;
                    n_state = S_T0_CMP;
                end
            end
            S_T0_CMP: begin
                if (i_sts.v_lt) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_RD_T1;
                    n_state = S_T1_CMP;
                end
            end
            S_T1_CMP: begin
                if (i_sts.v_le) begin
                    o_cmd   = DP_INSIDE;
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_K_INC;
                    n_state = S_T2_RD;
                end
            end
            // interval finished, look at the next one
            S_T2_RD: begin
                if (i_sts.k_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_RD_T0;
                    n_state = S_T2_CMP;
                end
            end
            S_T2_CMP: begin
                o_cmd   = DP_T2_EVAL;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd   = DP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* design/interval_union_set_unit.sv */
// interval_union_set_unit: top level of the interval union set unit
// joins the controller isu_ctrl and the datapath isu_dp; depends on isu_pkg
//
// Keeps up to MAX_INTERVALS disjoint closed intervals as a sorted boundary list in a
// single-port-write, registered-read memory of 2*MAX_INTERVALS entries. One item is
// in work at a time; the result beat sits in an output register, so the next input
// beat is taken while an earlier result still waits. An add's search reads every
// boundary not above the end of the new interval, plus up to two more, and the add
// then moves the boundaries beyond the merged span to open or close the gap; the
// search and the move share the one memory read port. A rejected add leaves the
// table unchanged.
module interval_union_set_unit import isu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_dp_op  cmd;
    t_dp_sts sts;

    // sequencer
    isu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage and compare logic
    isu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* sim/interval_union_set_unit_tb.sv */
// interval_union_set_unit_tb: self-checking bench for the interval union set unit
// drives add, begin, test and advance beats and checks every result beat against an
// in-bench interval table model; depends on isu_pkg and interval_union_set_unit
module interval_union_set_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import isu_pkg::*;

    typedef struct {
        t_in_beat beat;
        bit       hold;
    } pending_beat_t;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } stall_mode_t;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data  = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    // beats waiting to be driven and results waiting to arrive
    pending_beat_t pending_beats[$];
    t_out_beat     expected_results[$];
    int            mismatches = 0;

    // model of the interval table
    logic [VALUE_BITS-1:0] iv_bounds [SLOTS];
    int unsigned           iv_count  = 0;
    int unsigned           scan_idx  = 0;
    logic [VALUE_BITS-1:0] scan_pos  = '0;

    // driver pacing
    int          gap_left   = 0;
    int          burst_left = 1;
    bit          took_beat;
    pending_beat_t next_beat;

    // receiver pacing
    stall_mode_t stall_mode      = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_run_left  = 0;

    interval_union_set_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // merge [s, e] into the table, returns the add status
    function automatic t_status merge_interval(logic [VALUE_BITS-1:0] s,
                                               logic [VALUE_BITS-1:0] e);
        int unsigned           nb;
        int unsigned           i;
        int unsigned           j;
        int unsigned           cnt;
        logic [VALUE_BITS-1:0] lo;
        logic [VALUE_BITS-1:0] hi;
        logic [VALUE_BITS-1:0] moved [SLOTS];
        nb = 2 * iv_count;
        if (s >= e)
            return ST_BAD_ORDER;
        i = 0;
        while (i < nb && iv_bounds[i] < s)
            i++;
        j = i;
        while (j < nb && iv_bounds[j] <= e)
            j++;
        // start inside a stored interval extends the low end
        if (i % 2 == 1) begin
            i--;
            lo = iv_bounds[i];
        end else begin
            lo = s;
        end
        // end inside a stored interval extends the high end
        if (j % 2 == 1) begin
            hi = iv_bounds[j];
            j++;
        end else begin
            hi = e;
        end
        cnt = iv_count - (j - i) / 2 + 1;
        if (cnt > MAX_INTERVALS)
            return ST_FULL;
        moved = iv_bounds;
        for (int k = 0; k < int'(nb - j); k++)
            iv_bounds[i + 2 + k] = moved[j + k];
        iv_bounds[i]     = lo;
        iv_bounds[i + 1] = hi;
        iv_count = cnt;
        return ST_OK;
    endfunction

    // inside test at the scan position, steps past at most one finished interval
    function automatic logic scan_test();
        if (scan_idx >= iv_count)
            return 1'b0;
        if (scan_pos < iv_bounds[2 * scan_idx])
            return 1'b0;
        if (scan_pos <= iv_bounds[2 * scan_idx + 1])
            return 1'b1;
        scan_idx++;
        if (scan_idx < iv_count)
            return scan_pos >= iv_bounds[2 * scan_idx];
        return 1'b0;
    endfunction

    // expected result beat for one accepted input beat
    function automatic t_out_beat predict_result(t_in_beat b);
        t_out_beat r;
        r = '0;
        case (b.op)
            OP_ADD: begin
                r.status = merge_interval(b.range_start, b.range_end);
            end
            OP_BEGIN: begin
                scan_idx = 0;
                scan_pos = '0;
            end
            OP_TEST: begin
                r.inside_res = scan_test();
            end
            OP_ADVANCE: begin
                scan_pos = scan_pos + 1'b1;
            end
        endcase
        r.interval_count = CNT_W'(iv_count);
        return r;
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        return VALUE_BITS'($urandom());
    endfunction

    task automatic push_item(t_op op, logic [VALUE_BITS-1:0] s, logic [VALUE_BITS-1:0] e,
                             bit hold = 1'b0);
        pending_beat_t p;
        p.beat.op          = op;
        p.beat.range_start = s;
        p.beat.range_end   = e;
        p.hold             = hold;
        pending_beats.push_back(p);
    endtask

    // non-add beat with random unused range fields
    task automatic push_op(t_op op);
        push_item(op, rand_value(), rand_value());
    endtask

    // small add near zero where the scans can reach it
    task automatic push_low_add();
        logic [VALUE_BITS-1:0] s;
        s = VALUE_BITS'($urandom_range(0, 100));
        push_item(OP_ADD, s, s + VALUE_BITS'($urandom_range(0, 6)));
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    // driver: bursts of beats with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took_beat = i_in_valid && !o_in_stall;
            if (took_beat)
                expected_results.push_back(predict_result(i_in_data));
            if (!i_in_valid || took_beat) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_beats[0].hold && expected_results.size() != 0) begin
                    // drain every outstanding result before this beat
                    i_in_valid <= 1'b0;
                end else begin
                    next_beat = pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_data  <= next_beat.beat;
                    burst_left--;
                    if (burst_left <= 0) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                gap_left   = 0;
                                burst_left = $urandom_range(20, 60);
                            end
                            3: begin
                                gap_left   = $urandom_range(10, 40);
                                burst_left = $urandom_range(1, 8);
                            end
                            default: begin
                                gap_left   = $urandom_range(1, 4);
                                burst_left = $urandom_range(1, 8);
                            end
                        endcase
                    end
                end
            end
        end
    end

    // receiver stall pattern, switching at random among none, light, heavy and runs modes
    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      <= stall_mode_t'($urandom_range(0, 3));
            stall_mode_left <= $urandom_range(20, 400);
        end else begin
            stall_mode_left <= stall_mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_run_left == 0) begin
                    i_out_stall    <= !i_out_stall;
                    stall_run_left <= $urandom_range(1, 30);
                end else begin
                    stall_run_left <= stall_run_left - 1;
                end
            end
        endcase
    end

    // monitor: compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat", longint'(o_out_data), 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.inside_res !== want.inside_res)
                    report_mismatch("inside_res", o_out_data.inside_res, want.inside_res);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.interval_count !== want.interval_count)
                    report_mismatch("interval_count", o_out_data.interval_count,
                                    want.interval_count);
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [VALUE_BITS-1:0] base;
        logic [VALUE_BITS-1:0] s;
        int                    phase_no;
        int                    fills;
        int                    steps;

        for (int k = 0; k < SLOTS; k++)
            iv_bounds[k] = '0;

        // directed: empty and inverted adds, extremes, touching and spanning merges
        push_op(OP_TEST);
        push_item(OP_ADD, 24'd5, 24'd5);
        push_item(OP_ADD, 24'd9, 24'd3);
        push_item(OP_ADD, 24'hFFFFFE, 24'hFFFFFF);
        push_item(OP_ADD, 24'h000000, 24'h000001);
        push_item(OP_ADD, 24'd10, 24'd20);
        push_item(OP_ADD, 24'd20, 24'd30);
        push_item(OP_ADD, 24'd40, 24'd50);
        push_item(OP_ADD, 24'd31, 24'd39);
        push_item(OP_ADD, 24'd25, 24'd45);
        push_item(OP_ADD, 24'd12, 24'd14);
        push_item(OP_ADD, 24'd3, 24'd8);
        push_item(OP_ADD, 24'hFFFFFF, 24'h000000);
        // directed scan, then an add in the middle of it
        push_op(OP_BEGIN);
        push_op(OP_TEST);
        push_op(OP_ADVANCE);
        push_op(OP_ADVANCE);
        push_op(OP_TEST);
        push_op(OP_ADVANCE);
        push_op(OP_TEST);
        push_item(OP_ADD, 24'd0, 24'd60, 1'b1);
        push_op(OP_TEST);
        push_op(OP_BEGIN);
        push_op(OP_TEST);

        // random phases; scan value wrap needs 2^24 advances and is out of reach here
        phase_no = 0;
        fills    = 0;
        while (pending_beats.size() < 1325) begin
            phase_no++;
            if (phase_no % 9 == 4 && fills < 4) begin
                // fill past capacity with disjoint intervals, then collapse them
                fills++;
                base = VALUE_BITS'($urandom_range(24'h100000, 24'hE00000));
                push_item(OP_ADD, base, base + 1'b1, 1'b1);
                for (int k = 1; k < 70; k++)
                    push_item(OP_ADD, base + VALUE_BITS'(3 * k), base + VALUE_BITS'(3 * k + 1));
                push_item(OP_ADD, base + VALUE_BITS'($urandom_range(0, 2)),
                          base + VALUE_BITS'($urandom_range(210, 230)));
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:39]: begin
                        // well-formed scan with random advance spacing
                        push_op(OP_BEGIN);
                        steps = $urandom_range(5, 40);
                        for (int k = 0; k < steps; k++) begin
                            repeat ($urandom_range(0, 3)) push_op(OP_ADVANCE);
                            if ($urandom_range(0, 11) == 0)
                                push_low_add();
                            push_op(OP_TEST);
                        end
                    end
                    [40:69]: begin
                        repeat ($urandom_range(1, 8)) push_low_add();
                    end
                    [70:81]: begin
                        // noise: high-region adds in either order and random ops
                        repeat ($urandom_range(1, 6)) begin
                            if ($urandom_range(0, 1) == 0)
                                push_item(OP_ADD, 24'hF00000 | VALUE_BITS'($urandom_range(0, 24'hFFFFF)),
                                          24'hF00000 | VALUE_BITS'($urandom_range(0, 24'hFFFFF)));
                            else
                                push_op(t_op'($urandom_range(1, 3)));
                        end
                    end
                    default: begin
                        // broken sequences: inverted adds, tests without a begin
                        s = VALUE_BITS'($urandom_range(0, 100));
                        push_item(OP_ADD, s, s - VALUE_BITS'($urandom_range(0, 5)));
                        repeat ($urandom_range(1, 4)) push_op(OP_TEST);
                        if ($urandom_range(0, 1) == 0)
                            push_op(OP_ADVANCE);
                    end
                endcase
            end
            if ($urandom_range(0, 49) == 0)
                push_item(OP_ADD, rand_value(), rand_value(), 1'b1);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit, several times the slowest legal run
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/isu_pkg.sv
design/isu_dp.sv
design/isu_ctrl.sv
design/interval_union_set_unit.sv
sim/interval_union_set_unit_tb.sv
